// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the spline interpolator.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/cst_pkg.sv =====
// Package for the cubic spline table interpolator: widths, codes and the
// item, command and status structs. No dependencies.
package cst_pkg;

   localparam int DATA_W         = 32;
   localparam int COEF_W         = 16;
   localparam int MU_W           = 17;
   localparam int MU_FRAC        = 16;
   localparam int CNT_W          = 9;
   localparam int IDX_W          = 10;
   localparam int CSR_W          = 64;
   localparam int CSR_IDX_W      = 3;
   localparam int NB_W           = DATA_W + 2;
   localparam int OPA_W          = 44;
   localparam int OPB_W          = 18;
   localparam int PROD_W         = OPA_W + OPB_W;
   localparam int ACC_W          = 52;
   localparam int A_W            = ACC_W - 12;
   localparam int V_W            = OPA_W;
   localparam int STEP_W         = 4;
   localparam int DEF_MAX_POINTS = 256;

   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_ROW0   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_ROW1   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_ROW2   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_ROW3   = 3'd4;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_DEGEN = 2'd2;

   localparam logic [2:0] XS_NONE  = 3'd0;
   localparam logic [2:0] XS_FIRST = 3'd1;
   localparam logic [2:0] XS_LAST  = 3'd2;
   localparam logic [2:0] XS_MID   = 3'd3;
   localparam logic [2:0] XS_LEFT  = 3'd4;
   localparam logic [2:0] XS_RIGHT = 3'd5;

   localparam logic [1:0] EMIT_NONE  = 2'd0;
   localparam logic [1:0] EMIT_OK    = 2'd1;
   localparam logic [1:0] EMIT_RANGE = 2'd2;
   localparam logic [1:0] EMIT_DEGEN = 2'd3;

   typedef struct packed {
      logic                     kind;
      logic [7:0]               point_index;
      logic signed [DATA_W-1:0] point_x;
      logic signed [DATA_W-1:0] point_y;
      logic signed [DATA_W-1:0] query_t;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic [1:0]               status;
   } rsp_type;

   typedef struct packed {
      logic              accept_load;
      logic              accept_query;
      logic [2:0]        x_sel;
      logic              cap_lo;
      logic              search_init;
      logic              search_step;
      logic              cap_xl;
      logic              cap_xr;
      logic              div_init;
      logic              div_step;
      logic              y_rd;
      logic              nb_build;
      logic              mac_go;
      logic              hor_init;
      logic              hor_mul;
      logic              hor_add;
      logic [STEP_W-1:0] step;
      logic [1:0]        emit;
   } cmd_type;

   typedef struct packed {
      logic out_of_range;
      logic search_done;
      logic degen;
      logic mu_direct;
   } stat_type;

endpackage

// ===== rtl/cst_ctrl.sv =====
// Sequencer for the spline interpolator: one query at a time through range
// check, search, divide, gather, matrix product and Horner steps. Uses cst_pkg.
module cst_ctrl
   import cst_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic     req_kind,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_X0    = 5'd1;
   localparam logic [4:0] S_XN    = 5'd2;
   localparam logic [4:0] S_RANGE = 5'd3;
   localparam logic [4:0] S_PROBE = 5'd4;
   localparam logic [4:0] S_CMP   = 5'd5;
   localparam logic [4:0] S_XL    = 5'd6;
   localparam logic [4:0] S_XR    = 5'd7;
   localparam logic [4:0] S_CHK   = 5'd8;
   localparam logic [4:0] S_DIV   = 5'd9;
   localparam logic [4:0] S_YRD   = 5'd10;
   localparam logic [4:0] S_YLAST = 5'd11;
   localparam logic [4:0] S_NB    = 5'd12;
   localparam logic [4:0] S_MAC   = 5'd13;
   localparam logic [4:0] S_MACW  = 5'd14;
   localparam logic [4:0] S_HINIT = 5'd15;
   localparam logic [4:0] S_HMUL  = 5'd16;
   localparam logic [4:0] S_HADD  = 5'd17;
   localparam logic [4:0] S_DONE  = 5'd18;

   logic [4:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      cmd      = '0;
      cmd.step = step_ff;
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_kind == KIND_QUERY) begin
                  cmd.accept_query = 1'b1;
                  state_in         = S_X0;
               end else begin
                  cmd.accept_load = 1'b1;
               end
            end
         end
         S_X0: begin
            cmd.x_sel = XS_FIRST;
            state_in  = S_XN;
         end
         S_XN: begin
            cmd.x_sel  = XS_LAST;
            cmd.cap_lo = 1'b1;
            state_in   = S_RANGE;
         end
         S_RANGE: begin
            if (stat.out_of_range) begin
               cmd.emit = EMIT_RANGE;
               state_in = S_IDLE;
            end else begin
               cmd.search_init = 1'b1;
               state_in        = S_PROBE;
            end
         end
         S_PROBE: begin
            if (stat.search_done) begin
               cmd.x_sel = XS_LEFT;
               state_in  = S_XL;
            end else begin
               cmd.x_sel = XS_MID;
               state_in  = S_CMP;
            end
         end
         S_CMP: begin
            cmd.search_step = 1'b1;
            state_in        = S_PROBE;
         end
         S_XL: begin
            cmd.x_sel  = XS_RIGHT;
            cmd.cap_xl = 1'b1;
            state_in   = S_XR;
         end
         S_XR: begin
            cmd.cap_xr = 1'b1;
            state_in   = S_CHK;
         end
         S_CHK: begin
            step_in = '0;
            if (stat.degen) begin
               cmd.emit = EMIT_DEGEN;
               state_in = S_IDLE;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = stat.mu_direct ? S_YRD : S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == '1) begin
               state_in = S_YRD;
            end
         end
         S_YRD: begin
            cmd.y_rd = 1'b1;
            step_in  = step_ff + 1'b1;
            if (step_ff == STEP_W'(7)) begin
               step_in  = '0;
               state_in = S_YLAST;
            end
         end
         S_YLAST: begin
            state_in = S_NB;
         end
         S_NB: begin
            cmd.nb_build = 1'b1;
            step_in      = '0;
            state_in     = S_MAC;
         end
         S_MAC: begin
            cmd.mac_go = 1'b1;
            step_in    = step_ff + 1'b1;
            if (step_ff == '1) begin
               state_in = S_MACW;
            end
         end
         S_MACW: begin
            state_in = S_HINIT;
         end
         S_HINIT: begin
            cmd.hor_init = 1'b1;
            step_in      = STEP_W'(1);
            state_in     = S_HMUL;
         end
         S_HMUL: begin
            cmd.hor_mul = 1'b1;
            state_in    = S_HADD;
         end
         S_HADD: begin
            cmd.hor_add = 1'b1;
            if (step_ff == STEP_W'(3)) begin
               state_in = S_DONE;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = S_HMUL;
            end
         end
         S_DONE: begin
            cmd.emit = EMIT_OK;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== rtl/cst_dpath.sv =====
// Datapath of the spline interpolator: sample memories, config registers,
// search bounds, divider, shared multiplier, accumulator and result register.
// Uses cst_pkg.
module cst_dpath
   import cst_pkg::*;
#(
   parameter int MAX_POINTS = DEF_MAX_POINTS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  req_type              req_item,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  cmd_type              cmd,
   output stat_type             stat,
   output logic                 rsp_strobe,
   output rsp_type              rsp_item
);

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

   // configuration
   logic [CNT_W-1:0] count_ff;
   logic [CSR_W-1:0] coef_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_W'(2);
         for (int i = 0; i < 4; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_POINT_COUNT: count_ff   <= csr_wdata[CNT_W-1:0];
            CSR_COEF_ROW0:   coef_ff[0] <= csr_wdata;
            CSR_COEF_ROW1:   coef_ff[1] <= csr_wdata;
            CSR_COEF_ROW2:   coef_ff[2] <= csr_wdata;
            CSR_COEF_ROW3:   coef_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // query operands
   logic signed [DATA_W-1:0] t_ff;
   logic [IDX_W-1:0]         n_ff, n_in;

   always_comb begin
      if (count_ff < CNT_W'(2)) begin
         n_in = IDX_W'(2);
      end else if (int'(count_ff) > MAX_POINTS) begin
         n_in = IDX_W'(MAX_POINTS);
      end else begin
         n_in = IDX_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept_query) begin
         t_ff <= req_item.query_t;
         n_ff <= n_in;
      end
   end

   // sample memories
   logic signed [DATA_W-1:0] x_mem [MAX_POINTS];
   logic signed [DATA_W-1:0] y_mem [MAX_POINTS];
   logic signed [DATA_W-1:0] x_rd_ff, y_rd_ff;
   logic [AW-1:0]            wr_addr, x_addr, y_addr;
   logic                     mem_we;
   logic [IDX_W-1:0]         x_idx, y_idx;

   assign mem_we  = cmd.accept_load && (int'(req_item.point_index) < MAX_POINTS);
   assign wr_addr = AW'(req_item.point_index);
   assign x_addr  = AW'(x_idx);
   assign y_addr  = AW'(y_idx);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         x_mem[wr_addr] <= req_item.point_x;
         y_mem[wr_addr] <= req_item.point_y;
      end
      x_rd_ff <= x_mem[x_addr];
      y_rd_ff <= y_mem[y_addr];
   end

   // binary search bounds
   logic [IDX_W-1:0] l_ff, r_ff, mid;
   logic [IDX_W:0]   lr_sum;
   logic             lo_ff;

   assign lr_sum = {1'b0, l_ff} + {1'b0, r_ff};
   assign mid    = lr_sum[IDX_W:1];

   always_comb begin
      case (cmd.x_sel)
         XS_FIRST: x_idx = '0;
         XS_LAST:  x_idx = n_ff - 1'b1;
         XS_MID:   x_idx = mid - 1'b1;
         XS_LEFT:  x_idx = l_ff - 1'b1;
         XS_RIGHT: x_idx = r_ff - 1'b1;
         default:  x_idx = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_lo) begin
         lo_ff <= (t_ff < x_rd_ff);
      end
      if (cmd.search_init) begin
         l_ff <= IDX_W'(1);
         r_ff <= n_ff + 1'b1;
      end else if (cmd.search_step) begin
         if (x_rd_ff < t_ff) begin
            l_ff <= mid;
         end else begin
            r_ff <= mid;
         end
      end
   end

   // segment and mu divider
   logic signed [DATA_W-1:0] xl_ff;
   logic signed [DATA_W:0]   d_ff, num_ff;
   logic [DATA_W-1:0]        rem_ff;
   logic [MU_W-1:0]          mu_ff;
   logic [DATA_W:0]          rem2, rem_sub;
   logic                     rem_ge, num_le0, num_ged;

   assign rem2    = {rem_ff, 1'b0};
   assign rem_sub = rem2 - {1'b0, d_ff[DATA_W-1:0]};
   assign rem_ge  = (rem2 >= {1'b0, d_ff[DATA_W-1:0]});
   assign num_le0 = num_ff[DATA_W] || (num_ff == '0);
   assign num_ged = (num_ff >= d_ff);

   always_ff @(posedge clock) begin
      if (cmd.cap_xl) begin
         xl_ff <= x_rd_ff;
      end
      if (cmd.cap_xr) begin
         d_ff   <= {x_rd_ff[DATA_W-1], x_rd_ff} - {xl_ff[DATA_W-1], xl_ff};
         num_ff <= {t_ff[DATA_W-1], t_ff} - {xl_ff[DATA_W-1], xl_ff};
      end
      if (cmd.div_init) begin
         rem_ff <= num_ff[DATA_W-1:0];
         if (num_le0) begin
            mu_ff <= '0;
         end else if (num_ged) begin
            mu_ff <= MU_W'(1) << MU_FRAC;
         end else begin
            mu_ff <= '0;
         end
      end else if (cmd.div_step) begin
         rem_ff <= rem_ge ? rem_sub[DATA_W-1:0] : rem2[DATA_W-1:0];
         mu_ff  <= {mu_ff[MU_W-2:0], rem_ge};
      end
   end

   assign stat.out_of_range = lo_ff || (t_ff > x_rd_ff);
   assign stat.search_done  = ((r_ff - l_ff) <= IDX_W'(1));
   assign stat.degen        = d_ff[DATA_W] || (d_ff == '0);
   assign stat.mu_direct    = num_le0 || num_ged;

   // ordinate gather: y0, y1, y[n-2], y[n-1], then the four neighbors
   logic [IDX_W:0]           lj, lj_m2;
   logic [3:0]               y_tag_ff;
   logic signed [DATA_W-1:0] yv_ff [8];

   assign lj    = {1'b0, l_ff} + (IDX_W + 1)'(cmd.step[1:0]);
   assign lj_m2 = lj - (IDX_W + 1)'(2);

   always_comb begin
      case (cmd.step[2:0])
         3'd0:    y_idx = '0;
         3'd1:    y_idx = IDX_W'(1);
         3'd2:    y_idx = n_ff - IDX_W'(2);
         3'd3:    y_idx = n_ff - 1'b1;
         default: begin
            if (lj < (IDX_W + 1)'(2) || lj_m2 >= {1'b0, n_ff}) begin
               y_idx = '0;
            end else begin
               y_idx = lj_m2[IDX_W-1:0];
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         y_tag_ff <= '0;
      end else begin
         y_tag_ff <= {cmd.y_rd, cmd.step[2:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (y_tag_ff[3]) begin
         yv_ff[y_tag_ff[2:0]] <= y_rd_ff;
      end
   end

   // neighbors with linear extension at both ends
   logic signed [NB_W-1:0] ext_lo, ext_hi;
   logic signed [NB_W-1:0] nb_ff [4];
   logic [IDX_W:0]         g [4];

   assign ext_lo = (NB_W'(yv_ff[0]) <<< 1) - NB_W'(yv_ff[1]);
   assign ext_hi = (NB_W'(yv_ff[3]) <<< 1) - NB_W'(yv_ff[2]);

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         g[j] = {1'b0, l_ff} - (IDX_W + 1)'(1) + (IDX_W + 1)'(j);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.nb_build) begin
         for (int j = 0; j < 4; j++) begin
            if (g[j] == '0) begin
               nb_ff[j] <= ext_lo;
            end else if (g[j] >= {1'b0, n_ff} + 1'b1) begin
               nb_ff[j] <= ext_hi;
            end else begin
               nb_ff[j] <= NB_W'(yv_ff[4 + j]);
            end
         end
      end
   end

   // shared multiplier: matrix products, then Horner products
   logic signed [OPA_W-1:0]  op_a;
   logic signed [OPB_W-1:0]  op_b;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [COEF_W-1:0] coef_sel;
   logic [1:0]               row, col;
   logic [4:0]               mac_tag_ff;
   logic signed [V_W-1:0]    v_ff;

   assign row      = cmd.step[3:2];
   assign col      = cmd.step[1:0];
   assign coef_sel = coef_ff[row][{col, 4'b0000} +: COEF_W];

   always_comb begin
      if (cmd.hor_mul) begin
         op_a = v_ff;
         op_b = {1'b0, mu_ff};
      end else begin
         op_a = OPA_W'(nb_ff[col]);
         op_b = OPB_W'(coef_sel);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mac_go || cmd.hor_mul) begin
         prod_ff <= op_a * op_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_tag_ff <= '0;
      end else begin
         mac_tag_ff <= {cmd.mac_go, cmd.step};
      end
   end

   // accumulate one matrix row; round off the 12 coefficient fraction bits of each row sum
   logic signed [ACC_W-1:0] acc_ff, acc_sum, acc_rnd;
   logic signed [A_W-1:0]   a_ff [4];

   assign acc_sum = ((mac_tag_ff[1:0] == 2'd0) ? ACC_W'(0) : acc_ff)
                    + prod_ff[ACC_W-1:0];
   assign acc_rnd = acc_sum + ACC_W'(2048);

   always_ff @(posedge clock) begin
      if (mac_tag_ff[4]) begin
         acc_ff <= acc_sum;
         if (mac_tag_ff[1:0] == 2'd3) begin
            a_ff[mac_tag_ff[3:2]] <= acc_rnd[ACC_W-1:12];
         end
      end
   end

   // Horner evaluation
   logic signed [PROD_W-1:0] prod_rnd;

   assign prod_rnd = prod_ff + PROD_W'(32768);

   always_ff @(posedge clock) begin
      if (cmd.hor_init) begin
         v_ff <= V_W'(a_ff[0]);
      end else if (cmd.hor_add) begin
         v_ff <= prod_rnd[MU_FRAC+V_W-1:MU_FRAC] + V_W'(a_ff[cmd.step[1:0]]);
      end
   end

   // saturate and register the result
   logic signed [DATA_W-1:0] sat_value;
   logic                     fits;
   logic                     rsp_strobe_ff;
   rsp_type                  rsp_item_ff;

   assign fits = (v_ff[V_W-1:DATA_W-1] == '0) || (v_ff[V_W-1:DATA_W-1] == '1);

   always_comb begin
      if (fits) begin
         sat_value = v_ff[DATA_W-1:0];
      end else if (v_ff[V_W-1]) begin
         sat_value = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         sat_value = {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (cmd.emit != EMIT_NONE);
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.emit)
         EMIT_OK: begin
            rsp_item_ff.value  <= sat_value;
            rsp_item_ff.status <= ST_OK;
         end
         EMIT_RANGE: begin
            rsp_item_ff.value  <= '0;
            rsp_item_ff.status <= ST_RANGE;
         end
         EMIT_DEGEN: begin
            rsp_item_ff.value  <= '0;
            rsp_item_ff.status <= ST_DEGEN;
         end
         default: ;
      endcase
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

// ===== rtl/cubic_spline_table_interpolator_top.sv =====
// Top level of the cubic spline table interpolator.
// Instantiates cst_ctrl and cst_dpath; uses cst_pkg and assert_macros.svh.
//
// Usage:
//   Input: drive req_item and raise start; the item is taken at an edge
//   where start is high and busy is low. A load item (kind 0) writes one
//   sample point into slot point_index in that same edge and gives no
//   result; busy stays low, so loads can go every cycle. A query item
//   (kind 1) raises busy until its single result has been produced.
//   Output: the result sits on rsp_item for exactly one cycle with
//   rsp_strobe high. The receiver has no way to stall, so take it then.
//   Config: csr_we/csr_index/csr_wdata write point_count (index 0) and
//   the four coefficient rows (1 to 4); write only while idle.
//   A query ends at the range check when it is out of range; otherwise
//   it runs p = ceil(log2(n)) search probes, the divide for mu (skipped
//   when mu clamps to 0 or 1), the gather, the matrix products and the
//   Horner steps. Each probe has a read state and a compare state because
//   of the registered read port of the abscissa memory; the divider
//   retires one quotient bit a cycle; one shared multiplier does the
//   sixteen matrix products, one per cycle, then a drain state, then
//   three Horner steps, each a multiply and an add.
//   Reset clears control and config (point_count 2, coefficients 0); the
//   sample memories are not cleared and must be loaded before queries.
module cubic_spline_table_interpolator_top
   import cst_pkg::*;
#(
   parameter int MAX_POINTS = DEF_MAX_POINTS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_item,
   output logic                 rsp_strobe,
   output rsp_type              rsp_item,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

`include "assert_macros.svh"

   cmd_type  cmd;
   stat_type stat;

   // sequencer: one query in flight, loads taken in the idle state
   cst_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_item.kind),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   // memories, config, arithmetic and the result register
   cst_dpath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // An accepted query must make the block busy.
   `ASSERT_NEXT(a_query_busy, clock, reset, start && !busy && req_item.kind == KIND_QUERY, busy, "query accepted but busy dropped")
   // A load completes in its accept cycle.
   `ASSERT_NEXT(a_load_idle, clock, reset, start && !busy && req_item.kind == KIND_LOAD, !busy, "load left the block busy")
   // Every result comes from a query in flight.
   `ASSERT_IMPLIES(a_rsp_from_query, clock, reset, rsp_strobe, $past(busy), "result without a query in flight")
   // Result strobes never come back to back.
   `ASSERT_NEXT(a_rsp_single, clock, reset, rsp_strobe, !rsp_strobe, "result repeated")
   // Error results carry a zero value.
   `ASSERT_IMPLIES(a_err_zero, clock, reset, rsp_strobe && rsp_item.status != ST_OK, rsp_item.value == '0, "error result with nonzero value")

endmodule

// ===== bench/tb_cubic_spline_table_interpolator_top.sv =====
// Self-checking bench for cubic_spline_table_interpolator_top: loads sample
// tables, queries them and checks every result against a built-in predictor.
// Depends on cst_pkg and the RTL of the interpolator only.
module tb_cubic_spline_table_interpolator_top;
   timeunit 1ns;
   timeprecision 1ps;
   import cst_pkg::*;

   localparam int NPTS     = 256;
   localparam int IDLE_MAX = 3000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_item = '0;
   logic                 rsp_strobe;
   rsp_type              rsp_item;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_POINT_COUNT;
   logic [CSR_W-1:0]     csr_wdata = '0;

   cubic_spline_table_interpolator_top #(.MAX_POINTS(NPTS)) dut (.*);

   always #5 clock = ~clock;

   // Predictor state: a copy of the sample table and of the registers.
   longint       x_tab[NPTS];
   longint       y_tab[NPTS];
   int unsigned  cnt_reg;
   logic [63:0]  coef_reg[4];
   rsp_type      pending_rsp[$];

   int errors;
   int n_loads, n_queries, n_ok, n_range, n_degen;
   int idle_cycles;
   int burst_left;

   task automatic report_mismatch(string what, longint got, longint exp_v);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp_v, $realtime);
      errors++;
   endtask

   // Ordinate at extended grid position g; 0 and n+1 extrapolate linearly.
   function automatic longint grid_ordinate(int g, int n);
      if (g == 0) return 2 * y_tab[0] - y_tab[1];
      if (g >= n + 1) return 2 * y_tab[n-1] - y_tab[n-2];
      return y_tab[g-1];
   endfunction

   function automatic rsp_type interpolate(logic signed [31:0] t_in);
      int      n, l, r, mid;
      longint  t, xl, xr, d, num, mu, acc, v, s;
      longint  term[4];
      rsp_type e;
      n = cnt_reg;
      if (n < 2) n = 2;
      if (n > NPTS) n = NPTS;
      t = t_in;
      e.value = '0;
      if (t < x_tab[0] || t > x_tab[n-1]) begin
         e.status = ST_RANGE;
         return e;
      end
      l = 1;
      r = n + 1;
      while (r - l > 1) begin
         mid = (l + r) / 2;
         if (x_tab[mid-1] < t) l = mid;
         else r = mid;
      end
      xl = x_tab[l-1];
      xr = x_tab[r-1];
      d  = xr - xl;
      if (d <= 0) begin
         e.status = ST_DEGEN;
         return e;
      end
      num = t - xl;
      if (num <= 0) mu = 0;
      else if (num >= d) mu = 65536;
      else mu = (num <<< 16) / d;
      for (int i = 0; i < 4; i++) begin
         acc = 0;
         for (int j = 0; j < 4; j++)
            acc += grid_ordinate(l - 1 + j, n) * longint'($signed(coef_reg[i][16*j +: 16]));
         term[i] = (acc + 2048) >>> 12;
      end
      v = term[0];
      for (int i = 1; i < 4; i++) v = ((v * mu + 32768) >>> 16) + term[i];
      s = v;
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      e.value  = s[31:0];
      e.status = ST_OK;
      return e;
   endfunction

   // Result checker: every strobe must match the oldest pending result.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected result value", rsp_item.value, 0);
         end else begin
            rsp_type e;
            e = pending_rsp.pop_front();
            if (rsp_item.status !== e.status)
               report_mismatch("status", rsp_item.status, e.status);
            if (rsp_item.value !== e.value)
               report_mismatch("value", rsp_item.value, e.value);
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_MAX) begin
         $display("Watchdog expired after %0d idle cycles", IDLE_MAX);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Send one item; called and returns at a falling edge. Items come in bursts with random gaps between them.
   task automatic send_item(req_type it);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      burst_left--;
      while (busy) @(negedge clock);
      start    = 1'b1;
      req_item = it;
      @(posedge clock);
      if (it.kind == KIND_LOAD) begin
         x_tab[it.point_index] = longint'(it.point_x);
         y_tab[it.point_index] = longint'(it.point_y);
         n_loads++;
      end else begin
         rsp_type e;
         e = interpolate(it.query_t);
         pending_rsp.push_back(e);
         n_queries++;
         case (e.status)
            ST_OK:    n_ok++;
            ST_RANGE: n_range++;
            default:  n_degen++;
         endcase
      end
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic load_point(int idx, logic signed [31:0] px, logic signed [31:0] py);
      req_type it;
      it = '0;
      it.kind        = KIND_LOAD;
      it.point_index = idx[7:0];
      it.point_x     = px;
      it.point_y     = py;
      it.query_t     = $urandom;
      send_item(it);
   endtask

   task automatic query_at(logic signed [31:0] t);
      req_type it;
      it = '0;
      it.kind        = KIND_QUERY;
      it.point_index = $urandom;
      it.point_x     = $urandom;
      it.point_y     = $urandom;
      it.query_t     = t;
      send_item(it);
   endtask

   // Hold until every pending result has come and the block is idle.
   task automatic drain;
      while (pending_rsp.size() != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] val);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_POINT_COUNT) cnt_reg = val[8:0];
      else coef_reg[idx - CSR_COEF_ROW0] = val;
   endtask

   function automatic logic [63:0] pack_row(int c0, int c1, int c2, int c3);
      return {c3[15:0], c2[15:0], c1[15:0], c0[15:0]};
   endfunction

   task automatic set_catmull_rom;
      write_reg(CSR_COEF_ROW0, pack_row(-2048, 6144, -6144, 2048));
      write_reg(CSR_COEF_ROW1, pack_row(4096, -10240, 8192, -2048));
      write_reg(CSR_COEF_ROW2, pack_row(-2048, 0, 2048, 0));
      write_reg(CSR_COEF_ROW3, pack_row(0, 4096, 0, 0));
   endtask

   // Fill the whole table once so that no query can read an unwritten slot.
   task automatic test_full_table;
      write_reg(CSR_POINT_COUNT, 64'd256);
      set_catmull_rom();
      for (int i = 0; i < NPTS; i++)
         load_point(i, (i - 128) * 65536, (i - 100) * (i - 30) * 512);
   endtask

   // Table ends, range edges, extrapolated end segments, count clamping,
   // degenerate segment, field extremes and saturation.
   task automatic test_directed;
      query_at(-128 * 65536);
      query_at(127 * 65536);
      query_at(-128 * 65536 - 1);
      query_at(127 * 65536 + 1);
      query_at(32'sh8000_0000);
      query_at(32'sh7fff_ffff);
      query_at(-128 * 65536 + 32768);
      query_at(126 * 65536 + 1);
      query_at(5 * 65536 + 12345);
      drain();
      write_reg(CSR_POINT_COUNT, 64'd0);
      query_at(-127 * 65536 - 100);
      query_at(-126 * 65536);
      drain();
      write_reg(CSR_POINT_COUNT, 64'h1ff);
      query_at(127 * 65536);
      query_at(100 * 65536 + 7);
      drain();
      write_reg(CSR_POINT_COUNT, 64'd2);
      load_point(0, 32'sh8000_0000, 32'sh8000_0000);
      load_point(1, 32'sh7fff_ffff, 32'sh7fff_ffff);
      query_at(0);
      query_at(32'sh7fff_ffff);
      load_point(1, 32'sh8000_0000, 32'sh7fff_ffff);
      query_at(32'sh8000_0000);
      drain();
      write_reg(CSR_COEF_ROW3, {4{16'sh7fff}});
      write_reg(CSR_COEF_ROW0, {4{16'sh8000}});
      load_point(1, 32'sh7fff_ffff, 32'sh7fff_ffff);
      query_at(32'sh4000_0000);
      drain();
      write_reg(CSR_COEF_ROW3, 64'h0000_8000_8000_0000);
      query_at(32'sh0000_0000);
      drain();
   endtask

   // Random phases: new registers, a fresh table for the points in use,
   // then mostly in-range queries with some loads and wild abscissae.
   task automatic test_random_phases;
      int n, mode, span, seg, num_q;
      longint base, step, room, xv, t;
      for (int ph = 0; ph < 10; ph++) begin
         drain();
         case ($urandom_range(0, 7))
            0: n = 2;
            1: n = 256;
            2: n = $urandom_range(0, 1);
            3: n = $urandom_range(257, 511);
            default: n = $urandom_range(3, 24);
         endcase
         write_reg(CSR_POINT_COUNT, 64'(n));
         if (n < 2) n = 2;
         if (n > NPTS) n = NPTS;
         if ($urandom_range(0, 2) == 0) set_catmull_rom();
         else
            for (int i = 0; i < 4; i++)
               write_reg(CSR_IDX_W'(CSR_COEF_ROW0 + i),
                         ($urandom_range(0, 1) != 0) ? {$urandom, $urandom}
                         : pack_row($urandom_range(0, 8192) - 4096,
                                    $urandom_range(0, 8192) - 4096,
                                    $urandom_range(0, 8192) - 4096,
                                    $urandom_range(0, 8192) - 4096));
         mode = $urandom_range(0, 9);
         base = longint'($signed($urandom)) >>> $urandom_range(0, 8);
         room = 64'sd2147483647 - base;
         span = $urandom_range(0, 3);
         xv   = base;
         for (int i = 0; i < n; i++) begin
            if (mode == 9) xv = longint'($signed($urandom));
            else if (i > 0) begin
               step = (span == 0) ? room / n : $urandom_range(1, 1 << (4 * span + 8));
               if (step > room / n) step = room / n;
               if (step < 1) step = 1;
               if (mode == 8 && $urandom_range(0, 3) == 0) step = 0;
               xv += step;
            end
            load_point(i, xv[31:0], ($urandom_range(0, 1) != 0) ? $urandom
                                     : $urandom_range(0, 1 << 21) - (1 << 20));
         end
         // Occasionally wait for all results before resuming.
         if (ph % 5 == 0) drain();
         num_q = (n > 100) ? 15 : 26;
         for (int q = 0; q < num_q; q++) begin
            if ($urandom_range(0, 9) == 0) begin
               seg = $urandom_range(0, n - 1);
               load_point(seg, x_tab[seg][31:0], $urandom);
            end else if ($urandom_range(0, 9) == 0)
               query_at($urandom);
            else if (x_tab[0] <= x_tab[n-1]) begin
               seg = $urandom_range(0, n - 2);
               if (x_tab[seg+1] > x_tab[seg])
                  t = x_tab[seg] + longint'({$urandom, $urandom} % (x_tab[seg+1] - x_tab[seg] + 1));
               else
                  t = x_tab[seg] + $urandom_range(0, 2) - 1;
               if (t < x_tab[0] || t > x_tab[n-1]) t = x_tab[0];
               query_at(t[31:0]);
            end else
               query_at(x_tab[$urandom_range(0, n - 1)][31:0]);
         end
      end
      drain();
   endtask

   initial begin
      errors = 0;
      n_loads = 0; n_queries = 0; n_ok = 0; n_range = 0; n_degen = 0;
      burst_left = 0;
      cnt_reg = 2;
      for (int i = 0; i < 4; i++) coef_reg[i] = '0;
      for (int i = 0; i < NPTS; i++) begin
         x_tab[i] = 0;
         y_tab[i] = 0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_full_table();
      test_directed();
      test_random_phases();
      drain();
      repeat (100) @(posedge clock);
      $display("Covered %0d loads and %0d queries: %0d ok, %0d out of range, %0d degenerate",
               n_loads, n_queries, n_ok, n_range, n_degen);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches, %0d results missing", errors, pending_rsp.size());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
